// ===== src/rcb_pkg.sv =====
// Shared types, constants and helper functions for the received chunk bitmap.
// Used by rcb_byte_ram, rcb_ctrl and received_chunk_bitmap_core.
`timescale 1ns / 1ps

package rcb_pkg;

    localparam int MAX_BITS    = 65536;
    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = 17;
    localparam int BIDX_W      = 16;
    localparam int YIDX_W      = 13;

    typedef enum logic [2:0] {
        KIND_RESIZE  = 3'd0,
        KIND_WRITE   = 3'd1,
        KIND_QUERY   = 3'd2,
        KIND_REWIND  = 3'd3,
        KIND_FIND    = 3'd4,
        KIND_MERGE   = 3'd5,
        KIND_RECOUNT = 3'd6
    } rcb_kind_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [3:0] NIB_MASK = 4'hF;
    localparam logic [2:0] NIBBLE_ONES [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    typedef struct packed {
        logic [2:0]        kind;
        logic [BIDX_W-1:0] bit_index;
        logic              bit_value;
        logic [CNT_W-1:0]  new_size;
        logic [YIDX_W-1:0] byte_index;
        logic [7:0]        source_byte;
        logic [CNT_W-1:0]  source_count;
    } rcb_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  ones_count;
        logic              bit_state;
        logic [BIDX_W-1:0] found_index;
    } rcb_result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } rcb_mem_req_t;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        byte_ones = {1'b0, NIBBLE_ONES[b[3:0] & NIB_MASK]}
                  + {1'b0, NIBBLE_ONES[b[7:4] & NIB_MASK]};
    endfunction

    // Bits of byte b that lie below limit.
    function automatic logic [7:0] low_mask(input logic [ADDR_W-1:0] b,
                                            input logic [CNT_W-1:0]  limit);
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] diff;
        base = CNT_W'({b, 3'b000});
        diff = limit - base;
        if (base >= limit) begin
            low_mask = 8'h00;
        end else if (diff >= CNT_W'(8)) begin
            low_mask = 8'hFF;
        end else begin
            low_mask = 8'((9'd1 << diff[2:0]) - 9'd1);
        end
    endfunction

endpackage

// ===== src/rcb_byte_ram.sv =====
// Byte-wide bitmap storage: one write port, one registered read port.
// Depends on rcb_pkg for the request type and depth.
`timescale 1ns / 1ps

module rcb_byte_ram (
    input  logic                aclk,
    input  rcb_pkg::rcb_mem_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0] mem [rcb_pkg::STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        // hold read data until the next read
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rcb_ctrl.sv =====
// Operation sequencer: read-modify-write of bitmap bytes, scans and sweeps.
// Depends on rcb_pkg; drives the request port of rcb_byte_ram.
`timescale 1ns / 1ps

module rcb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  rcb_pkg::rcb_item_t    item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output rcb_pkg::rcb_result_t  res,
    output rcb_pkg::rcb_mem_req_t mem_req,
    input  logic [7:0]            mem_rdata
);

    localparam int CW = rcb_pkg::CNT_W;
    localparam int AW = rcb_pkg::ADDR_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } state_t;

    state_t             state_reg, state_next;
    rcb_pkg::rcb_item_t item_reg, item_next;
    logic [CW-1:0]      size_reg, size_next;
    logic [CW-1:0]      tally_reg, tally_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [AW:0]        sw_rd_reg, sw_rd_next;
    logic               sw_vld_reg, sw_vld_next;
    logic [AW-1:0]      sw_waddr_reg, sw_waddr_next;
    logic [CW-1:0]      acc_reg, acc_next;
    logic [CW-1:0]      limit_reg, limit_next;

    // datapath helpers
    logic [7:0]    bit_mask;
    logic          old_bit;
    logic [CW-1:0] merge_lim;
    logic [7:0]    merge_add;
    logic [7:0]    merge_new;
    logic [CW-1:0] find_base;
    logic [7:0]    find_hit;
    logic          hit_any;
    logic [2:0]    hit_k;
    logic [CW-1:0] found_pos;
    logic [7:0]    sw_masked;
    logic          sw_more;

    always_comb begin
        bit_mask  = 8'd1 << item_reg.bit_index[2:0];
        old_bit   = mem_rdata[item_reg.bit_index[2:0]];
        merge_lim = (size_reg < item_reg.source_count) ? size_reg : item_reg.source_count;
        merge_add = item_reg.source_byte & rcb_pkg::low_mask(item_reg.byte_index, merge_lim);
        merge_new = merge_add & ~mem_rdata;
        find_base = {1'b0, ptr_reg[15:3], 3'b000};
        for (int k = 0; k < 8; k++) begin
            find_hit[k] = (3'(k) >= ptr_reg[2:0])
                       && ((find_base + CW'(k)) < size_reg)
                       && (mem_rdata[k] == item_reg.bit_value);
        end
        hit_any = 1'b0;
        hit_k   = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (find_hit[k]) begin
                hit_any = 1'b1;
                hit_k   = 3'(k);
            end
        end
        found_pos = find_base + CW'(hit_k);
        sw_masked = mem_rdata & rcb_pkg::low_mask(sw_waddr_reg, limit_reg);
        sw_more   = sw_rd_reg < (AW+1)'(rcb_pkg::STORE_BYTES);
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        size_next     = size_reg;
        tally_next    = tally_reg;
        ptr_next      = ptr_reg;
        sw_rd_next    = sw_rd_reg;
        sw_vld_next   = sw_vld_reg;
        sw_waddr_next = sw_waddr_reg;
        acc_next      = acc_reg;
        limit_next    = limit_reg;
        mem_req       = '0;
        res_valid     = 1'b0;
        res           = '0;
        res.status    = rcb_pkg::ST_OK;
        res.ones_count = tally_reg;
        item_ready    = (state_reg == S_IDLE);

        unique case (state_reg)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sw_rd_reg[AW-1:0];
                mem_req.wdata = 8'h00;
                sw_rd_next    = sw_rd_reg + 1'b1;
                if (sw_rd_reg == (AW+1)'(rcb_pkg::STORE_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (item_valid) begin
                    item_next  = item;
                    mem_req.re = 1'b1;
                    case (item.kind)
                        rcb_pkg::KIND_MERGE: mem_req.raddr = item.byte_index;
                        rcb_pkg::KIND_FIND:  mem_req.raddr = ptr_reg[15:3];
                        default:             mem_req.raddr = item.bit_index[15:3];
                    endcase
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (item_reg.kind) inside
                    rcb_pkg::KIND_RESIZE, rcb_pkg::KIND_RECOUNT: begin
                        if (item_reg.kind == rcb_pkg::KIND_RESIZE
                            && item_reg.new_size > CW'(rcb_pkg::MAX_BITS)) begin
                            res_valid  = 1'b1;
                            res.status = rcb_pkg::ST_RANGE;
                            if (res_ready) begin
                                state_next = S_IDLE;
                            end
                        end else begin
                            sw_rd_next  = '0;
                            sw_vld_next = 1'b0;
                            acc_next    = '0;
                            limit_next  = (item_reg.kind == rcb_pkg::KIND_RESIZE)
                                        ? item_reg.new_size : CW'(rcb_pkg::MAX_BITS);
                            state_next  = S_SWEEP;
                        end
                    end

                    rcb_pkg::KIND_WRITE: begin
                        res_valid = 1'b1;
                        if ({1'b0, item_reg.bit_index} >= CW'(rcb_pkg::MAX_BITS)) begin
                            res.status = rcb_pkg::ST_RANGE;
                        end else begin
                            if (item_reg.bit_value && !old_bit) begin
                                tally_next = tally_reg + 1'b1;
                            end else if (!item_reg.bit_value && old_bit) begin
                                tally_next = tally_reg - 1'b1;
                            end
                            res.ones_count = tally_next;
                            mem_req.waddr  = item_reg.bit_index[15:3];
                            mem_req.wdata  = item_reg.bit_value ? (mem_rdata | bit_mask)
                                                                : (mem_rdata & ~bit_mask);
                            if (res_ready) begin
                                mem_req.we = 1'b1;
                                if ({1'b0, item_reg.bit_index} >= size_reg) begin
                                    size_next = {1'b0, item_reg.bit_index} + 1'b1;
                                end
                            end
                        end
                        if (!res_ready) begin
                            tally_next = tally_reg;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end

                    rcb_pkg::KIND_QUERY: begin
                        res_valid = 1'b1;
                        if ({1'b0, item_reg.bit_index} >= CW'(rcb_pkg::MAX_BITS)) begin
                            res.status = rcb_pkg::ST_RANGE;
                        end else if ({1'b0, item_reg.bit_index} < size_reg) begin
                            res.bit_state = old_bit;
                        end
                        if (res_ready) begin
                            state_next = S_IDLE;
                        end
                    end

                    rcb_pkg::KIND_REWIND: begin
                        res_valid = 1'b1;
                        if (res_ready) begin
                            ptr_next   = '0;
                            state_next = S_IDLE;
                        end
                    end

                    rcb_pkg::KIND_FIND: begin
                        if (ptr_reg >= size_reg) begin
                            res_valid  = 1'b1;
                            res.status = rcb_pkg::ST_NOT_FOUND;
                            if (res_ready) begin
                                state_next = S_IDLE;
                            end
                        end else if (hit_any) begin
                            res_valid       = 1'b1;
                            res.found_index = found_pos[15:0];
                            if (res_ready) begin
                                ptr_next   = found_pos + 1'b1;
                                state_next = S_IDLE;
                            end
                        end else if ((find_base + CW'(8)) >= size_reg) begin
                            res_valid  = 1'b1;
                            res.status = rcb_pkg::ST_NOT_FOUND;
                            if (res_ready) begin
                                ptr_next   = size_reg;
                                state_next = S_IDLE;
                            end
                        end else begin
                            // advance to the next byte and fetch it
                            ptr_next      = find_base + CW'(8);
                            mem_req.re    = 1'b1;
                            mem_req.raddr = ptr_reg[15:3] + 1'b1;
                        end
                    end

                    rcb_pkg::KIND_MERGE: begin
                        res_valid = 1'b1;
                        if ({1'b0, item_reg.byte_index} >= (AW+1)'(rcb_pkg::STORE_BYTES)) begin
                            res.status = rcb_pkg::ST_RANGE;
                        end else begin
                            res.ones_count = tally_reg + CW'(rcb_pkg::byte_ones(merge_new));
                            mem_req.waddr  = item_reg.byte_index[AW-1:0];
                            mem_req.wdata  = mem_rdata | merge_add;
                            if (res_ready) begin
                                mem_req.we = 1'b1;
                                tally_next = res.ones_count;
                            end
                        end
                        if (res_ready) begin
                            state_next = S_IDLE;
                        end
                    end

                    default: begin
                        res_valid = 1'b1;
                        if (res_ready) begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_SWEEP: begin
                if (sw_more) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sw_rd_reg[AW-1:0];
                    sw_rd_next    = sw_rd_reg + 1'b1;
                    sw_waddr_next = sw_rd_reg[AW-1:0];
                end
                sw_vld_next = sw_more;
                if (sw_vld_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = sw_waddr_reg;
                    mem_req.wdata = sw_masked;
                    acc_next      = acc_reg + CW'(rcb_pkg::byte_ones(sw_masked));
                end
                if (!sw_more && !sw_vld_reg) begin
                    res_valid      = 1'b1;
                    res.ones_count = acc_reg;
                    if (res_ready) begin
                        tally_next = acc_reg;
                        if (item_reg.kind == rcb_pkg::KIND_RESIZE) begin
                            size_next = limit_reg;
                        end
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            size_reg   <= '0;
            tally_reg  <= '0;
            ptr_reg    <= '0;
            sw_rd_reg  <= '0;
            sw_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            tally_reg  <= tally_next;
            ptr_reg    <= ptr_next;
            sw_rd_reg  <= sw_rd_next;
            sw_vld_reg <= sw_vld_next;
        end
        item_reg     <= item_next;
        sw_waddr_reg <= sw_waddr_next;
        acc_reg      <= acc_next;
        limit_reg    <= limit_next;
    end

endmodule

// ===== src/received_chunk_bitmap_core.sv =====
// Received chunk bitmap: a 64K-bit bitmap with size, ones count and scan pointer.
// After reset the block clears its 8192-byte store, one byte per cycle, and takes no
// word until the clear is done. Bit write and merge byte do one memory read, then the
// modify and write back; query and rewind do the memory read only. Find next reads the
// byte at the scan pointer and each further byte it must scan. Resize and recount sweep
// the whole store through the single read and single write port. One word is in work
// at a time; the output register holds a finished result while the next word is accepted.
// Depends on rcb_pkg, rcb_ctrl and rcb_byte_ram.
`timescale 1ns / 1ps

module received_chunk_bitmap_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [15:0] s_bit_index,
    input  logic        s_bit_value,
    input  logic [16:0] s_new_size,
    input  logic [12:0] s_byte_index,
    input  logic [7:0]  s_source_byte,
    input  logic [16:0] s_source_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [16:0] m_ones_count,
    output logic        m_bit_state,
    output logic [15:0] m_found_index
);

    rcb_pkg::rcb_item_t    item;
    rcb_pkg::rcb_result_t  res;
    rcb_pkg::rcb_result_t  out_reg, out_next;
    rcb_pkg::rcb_mem_req_t mem_req;
    logic [7:0]            mem_rdata;
    logic                  res_valid;
    logic                  res_ready;
    logic                  m_valid_reg, m_valid_next;

    always_comb begin
        item.kind         = s_kind;
        item.bit_index    = s_bit_index;
        item.bit_value    = s_bit_value;
        item.new_size     = s_new_size;
        item.byte_index   = s_byte_index;
        item.source_byte  = s_source_byte;
        item.source_count = s_source_count;
    end

    rcb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(s_valid),
        .item_ready(s_ready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    rcb_byte_ram u_ram (
        .aclk (aclk),
        .req  (mem_req),
        .rdata(mem_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_ones_count  = out_reg.ones_count;
    assign m_bit_state   = out_reg.bit_state;
    assign m_found_index = out_reg.found_index;

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_ones_count <= 17'(rcb_pkg::MAX_BITS))
        else $error("ones count exceeds capacity");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == rcb_pkg::ST_OK || m_status == rcb_pkg::ST_RANGE
                     || m_status == rcb_pkg::ST_NOT_FOUND))
        else $error("unknown status code");

    a_bit_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bit_state) |-> m_status == rcb_pkg::ST_OK)
        else $error("set bit reported with error status");

    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == rcb_pkg::ST_NOT_FOUND) |-> m_found_index == 16'd0)
        else $error("miss reported with nonzero index");

endmodule
